/* hdl/dled_pkg.sv */
// Shared types and constants for the DLE framed message deframer.
package dled_pkg;

  // Link control bytes.
  localparam logic [7:0] DLE_BYTE = 8'h10;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // Frame body limits.
  localparam int MAX_BODY      = 256;
  localparam int CNT_W         = $clog2(MAX_BODY + 1);
  localparam int FIRST_PAYLOAD = 13;
  localparam int MIN_BODY      = 14;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_B = 2'd1;

  // Configuration reset values.
  localparam logic [7:0] TYPE_A_RESET = 8'd147;
  localparam logic [7:0] TYPE_B_RESET = 8'd148;

  // Link phase of the deframer.
  typedef enum logic [1:0] {
    PH_HUNT     = 2'd0,
    PH_HUNT_DLE = 2'd1,
    PH_BODY     = 2'd2,
    PH_BODY_DLE = 2'd3
  } phase_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_t;

  // Accepted message types.
  typedef struct packed {
    logic [7:0] type_a;
    logic [7:0] type_b;
  } cfg_t;

  // Latched header fields.
  typedef struct packed {
    logic [7:0]  msg_type;
    logic [7:0]  priority_res;
    logic [23:0] pgn;
    logic [7:0]  destination;
    logic [7:0]  source_addr;
    logic [7:0]  data_len;
  } hdr_t;

  // One result transaction.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] position;
    hdr_t       hdr;
  } res_t;

endpackage

/* hdl/dle_framed_message_deframer.sv */
// Top level of the DLE STX/ETX framed message deframer.
// Takes one raw link byte per cycle and returns at most one result per byte: a delayed
// payload byte, or a frame status (good, checksum bad, short or aborted) with the latched
// header fields. A byte passes an input register and then the phase machine and body
// datapath into an output register, which holds the result until it is taken; bytes are
// taken back to back as long as the output register is drained.
module dle_framed_message_deframer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      kind,
  output logic [7:0]                      data_byte,
  output logic [7:0]                      position,
  output logic [7:0]                      msg_type,
  output logic [7:0]                      priority_res,
  output logic [23:0]                     pgn,
  output logic [7:0]                      destination,
  output logic [7:0]                      source_addr,
  output logic [7:0]                      data_len,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dled_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data
);
  import dled_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic res_valid;
  logic room;

  // Accepted message type registers.
  dled_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Deframing logic.
  dled_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .res_ready (room),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  dled_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_q     (res_q)
  );

  // Result fields.
  assign kind         = res_q.kind;
  assign data_byte    = res_q.data_byte;
  assign position     = res_q.position;
  assign msg_type     = res_q.hdr.msg_type;
  assign priority_res = res_q.hdr.priority_res;
  assign pgn          = res_q.hdr.pgn;
  assign destination  = res_q.hdr.destination;
  assign source_addr  = res_q.hdr.source_addr;
  assign data_len     = res_q.hdr.data_len;

endmodule

/* hdl/dled_cfg_regs.sv */
// Configuration registers holding the two accepted message types.
module dled_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dled_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  output dled_pkg::cfg_t                  cfg
);
  import dled_pkg::*;

  // Writes are always taken; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.type_a <= TYPE_A_RESET;
      cfg.type_b <= TYPE_B_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TYPE_A) begin
        cfg.type_a <= cfg_data;
      end
      if (cfg_index == CFG_TYPE_B) begin
        cfg.type_b <= cfg_data;
      end
    end
  end

endmodule

/* hdl/dled_core.sv */
// Input register, link phase machine and frame body datapath.
module dled_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      rx_byte,
  input  dled_pkg::cfg_t  cfg,
  input  logic            res_ready,
  output logic            res_valid,
  output dled_pkg::res_t  res
);
  import dled_pkg::*;

  // Input register.
  logic       inr_valid;
  logic [7:0] inr_byte;
  logic       fire;

  // Frame state.
  phase_t           phase, phase_next;
  logic [7:0]       sum, sum_next;
  logic [CNT_W-1:0] count, count_next;
  logic [7:0]       held, held_next;
  logic             held_v, held_v_next;
  hdr_t             hdr, hdr_next;

  // Byte decode.
  logic is_dle, is_stx, is_etx;
  logic body_go, start_go, close_go, overflow, reject;

  assign fire     = inr_valid && res_ready;
  assign in_ready = !inr_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      inr_valid <= 1'b0;
    end else if (in_ready) begin
      inr_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inr_byte <= rx_byte;
    end
  end

  // Classify the registered byte against the current phase.
  assign is_dle   = (inr_byte == DLE_BYTE);
  assign is_stx   = (inr_byte == STX_BYTE);
  assign is_etx   = (inr_byte == ETX_BYTE);
  assign body_go  = (phase == PH_BODY && !is_dle) || (phase == PH_BODY_DLE && is_dle);
  assign start_go = (phase == PH_HUNT_DLE || phase == PH_BODY_DLE) && is_stx;
  assign close_go = (phase == PH_BODY_DLE) && !is_dle && !is_stx;
  assign overflow = (count == CNT_W'(MAX_BODY));
  assign reject   = (count == '0) && (inr_byte != cfg.type_a) && (inr_byte != cfg.type_b);

  // Next link phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HUNT: begin
        if (is_dle) phase_next = PH_HUNT_DLE;
      end
      PH_HUNT_DLE: begin
        if (is_stx) phase_next = PH_BODY;
        else if (!is_dle) phase_next = PH_HUNT;
      end
      PH_BODY: begin
        if (is_dle) phase_next = PH_BODY_DLE;
        else if (overflow || reject) phase_next = PH_HUNT;
      end
      PH_BODY_DLE: begin
        if (is_dle) phase_next = (overflow || reject) ? PH_HUNT : PH_BODY;
        else if (is_stx) phase_next = PH_BODY;
        else phase_next = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // Body datapath and result.
  always_comb begin
    sum_next       = sum;
    count_next     = count;
    held_next      = held;
    held_v_next    = held_v;
    hdr_next       = hdr;
    res_valid      = 1'b0;
    res.kind       = KIND_ABORT;
    res.data_byte  = '0;
    res.position   = '0;
    if (start_go) begin
      sum_next    = '0;
      count_next  = '0;
      held_next   = '0;
      held_v_next = 1'b0;
      hdr_next    = '0;
    end else if (body_go) begin
      if (overflow) begin
        res_valid = 1'b1;
      end else if (!reject) begin
        sum_next = sum + inr_byte;
        unique case (count)
          CNT_W'(0):  hdr_next.msg_type          = inr_byte;
          CNT_W'(2):  hdr_next.priority_res      = inr_byte;
          CNT_W'(3):  hdr_next.pgn[7:0]          = inr_byte;
          CNT_W'(4):  hdr_next.pgn[15:8]         = inr_byte;
          CNT_W'(5):  hdr_next.pgn[23:16]        = inr_byte;
          CNT_W'(6):  hdr_next.destination       = inr_byte;
          CNT_W'(7):  hdr_next.source_addr       = inr_byte;
          CNT_W'(12): hdr_next.data_len          = inr_byte;
          default: ;
        endcase
        // Payload leaves one byte late so the checksum is never sent.
        if (count >= CNT_W'(FIRST_PAYLOAD)) begin
          if (held_v) begin
            res_valid     = 1'b1;
            res.kind      = KIND_PAYLOAD;
            res.data_byte = held;
            res.position  = 8'(count - CNT_W'(1));
          end
          held_next   = inr_byte;
          held_v_next = 1'b1;
        end
        count_next = count + CNT_W'(1);
      end
    end else if (close_go) begin
      res_valid = 1'b1;
      if (is_etx && count >= CNT_W'(MIN_BODY)) begin
        res.kind = (sum == '0) ? KIND_GOOD : KIND_BAD;
      end
    end
    // Only a byte that is actually waiting in the input register gives a result.
    if (!inr_valid) begin
      res_valid = 1'b0;
    end
    res.hdr = hdr_next;
  end

  // State update once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HUNT;
      sum    <= '0;
      count  <= '0;
      held   <= '0;
      held_v <= 1'b0;
      hdr    <= '0;
    end else if (fire) begin
      phase  <= phase_next;
      sum    <= sum_next;
      count  <= count_next;
      held   <= held_next;
      held_v <= held_v_next;
      hdr    <= hdr_next;
    end
  end

`ifndef SYNTHESIS
  // The body count never runs past the frame limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BODY))
    else $error("body count beyond limit");

  // A held payload byte exists only once the payload region is reached.
  a_held_region: assert property (@(posedge clk) disable iff (rst)
    held_v |-> count >= CNT_W'(MIN_BODY))
    else $error("held byte outside payload region");

  // No result is produced while hunting for a frame start.
  a_hunt_quiet: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT || phase == PH_HUNT_DLE) |-> !res_valid)
    else $error("result while hunting");

  // A frame start always clears the running sum and count.
  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    (fire && start_go) |=> (count == '0 && sum == '0 && !held_v))
    else $error("frame start did not clear state");
`endif

endmodule

/* hdl/dled_out_reg.sv */
// Output register that holds one result transaction until it is taken.
module dled_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  dled_pkg::res_t  res,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output dled_pkg::res_t  res_q
);
  import dled_pkg::*;

  // The register can take a new result when empty or being drained.
  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      res_q <= res;
    end
  end

endmodule
